// ----- src/wpp_pkg.sv -----
// ----------------------------------------------------------------------------
// wpp_pkg
// shared types and constants of the wave pcm16 mono stream parser
// ----------------------------------------------------------------------------
package wpp_pkg;

  // configuration register indexes
  localparam logic CFG_EXPECTED_RATE = 1'b0;
  localparam logic CFG_STREAM_LENGTH = 1'b1;
  localparam logic [31:0] EXPECTED_RATE_RST = 32'd48000;

  // chunk tags as little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // required fmt chunk field bytes
  localparam logic [7:0] FMT_PCM_TAG  = 8'd1;
  localparam logic [7:0] FMT_CHANNELS = 8'd1;
  localparam logic [7:0] FMT_ALIGN    = 8'd2;
  localparam logic [7:0] FMT_BITS     = 8'd16;
  localparam logic [4:0] FMT_MIN_SIZE = 5'd16;

  // command queue between parser and sample stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_LOW_BYTE,
    CMD_HIGH_BYTE,
    CMD_REJECT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  function automatic logic [7:0] tag_byte(logic [31:0] tag, logic [1:0] k);
    logic [31:0] sh;
    sh = tag >> {k, 3'b000};
    return sh[7:0];
  endfunction

endpackage

// ----- src/wpp_front.sv -----
// ----------------------------------------------------------------------------
// wpp_front
// byte parser: header and chunk walk, fmt checks, data byte classification
// ----------------------------------------------------------------------------
module wpp_front
  import wpp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_fire_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   first_byte_i,
  input  logic [31:0]            expected_rate_i,
  input  logic [LENGTH_BITS-1:0] limit_i,
  output logic                   cmd_valid_o,
  output cmd_t                   cmd_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK_HEAD,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] byte_pos_q, byte_pos_d;
  logic [31:0]            bytes_left_q, bytes_left_d;
  logic [31:0]            chunk_tag_q, chunk_tag_d;
  logic [31:0]            chunk_size_q, chunk_size_d;
  logic                   format_ok_q, format_ok_d;
  logic [3:0]             field_shift_q, field_shift_d;

  // state as seen by this byte, after a restart
  phase_e                 ph;
  logic [LENGTH_BITS-1:0] idx, pos_next;
  logic [31:0]            bl, bl_dec;
  logic                   fok;
  logic [3:0]             fs;
  logic [31:0]            size_new, room;
  logic                   reject, end_check;

  function automatic logic fmt_byte_ok(logic [3:0] k, logic [7:0] b, logic [31:0] rate);
    logic [31:0] sh;
    sh = rate >> {k[1:0], 3'b000};
    case (k) inside
      4'd0:                return b == FMT_PCM_TAG;
      4'd2:                return b == FMT_CHANNELS;
      4'd12:               return b == FMT_ALIGN;
      4'd14:               return b == FMT_BITS;
      4'd1, 4'd3, 4'd13, 4'd15: return b == 8'd0;
      [4'd4:4'd7]:         return b == sh[7:0];
      default:             return 1'b1;
    endcase
  endfunction

  always_comb begin
    ph  = first_byte_i ? PH_HEADER : phase_q;
    idx = first_byte_i ? '0 : byte_pos_q;
    bl  = first_byte_i ? '0 : bytes_left_q;
    fok = first_byte_i ? 1'b0 : format_ok_q;
    fs  = first_byte_i ? '0 : field_shift_q;

    pos_next = (idx == '1) ? idx : idx + 1'b1;
    bl_dec   = (bl != '0) ? bl - 32'd1 : bl;
    size_new = {data_byte_i, chunk_size_q[31:8]};
    room     = 32'(limit_i - pos_next);

    phase_d       = ph;
    byte_pos_d    = (ph == PH_DONE) ? idx : pos_next;
    bytes_left_d  = bl;
    chunk_tag_d   = chunk_tag_q;
    chunk_size_d  = chunk_size_q;
    format_ok_d   = fok;
    field_shift_d = fs;

    reject      = 1'b0;
    end_check   = 1'b1;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = CMD_REJECT;
    cmd_o.data  = data_byte_i;
    cmd_o.last  = 1'b0;

    case (ph)
      PH_HEADER: begin
        if (idx < LENGTH_BITS'(4) && data_byte_i != tag_byte(TAG_RIFF, idx[1:0])) begin
          reject = 1'b1;
        end else if (idx >= LENGTH_BITS'(8) && idx < LENGTH_BITS'(12) &&
                     data_byte_i != tag_byte(TAG_WAVE, idx[1:0])) begin
          reject = 1'b1;
        end
        if (idx >= LENGTH_BITS'(11)) begin
          phase_d       = PH_CHUNK_HEAD;
          field_shift_d = '0;
        end
      end
      PH_CHUNK_HEAD: begin
        if (fs < 4'd4) begin
          chunk_tag_d = {data_byte_i, chunk_tag_q[31:8]};
        end else begin
          chunk_size_d = size_new;
        end
        field_shift_d = fs + 4'd1;
        if (fs == 4'd7) begin
          field_shift_d = '0;
          bytes_left_d  = size_new + {31'd0, size_new[0]};
          if (pos_next > limit_i || size_new > room) begin
            reject = 1'b1;
          end else if (chunk_tag_q == TAG_FMT) begin
            if (size_new < 32'(FMT_MIN_SIZE)) reject = 1'b1;
            else phase_d = PH_FMT;
          end else if (chunk_tag_q == TAG_DATA) begin
            if (!fok || size_new == '0 || size_new[0]) reject = 1'b1;
            else begin
              bytes_left_d = size_new;
              phase_d      = PH_DATA;
            end
          end else begin
            phase_d = (bytes_left_d == '0) ? PH_CHUNK_HEAD : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (!fmt_byte_ok(fs, data_byte_i, expected_rate_i)) begin
          reject = 1'b1;
        end else begin
          bytes_left_d  = bl - 32'd1;
          field_shift_d = fs + 4'd1;
          if (fs == 4'd15) begin
            field_shift_d = '0;
            format_ok_d   = 1'b1;
            phase_d       = (bytes_left_d == '0) ? PH_CHUNK_HEAD : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        bytes_left_d = bl_dec;
        if (bl_dec == '0) phase_d = PH_CHUNK_HEAD;
      end
      PH_DATA: begin
        end_check    = 1'b0;
        bytes_left_d = bl_dec;
        cmd_valid_o  = 1'b1;
        if (bl_dec[0]) begin
          cmd_o.kind = CMD_LOW_BYTE;
        end else begin
          cmd_o.kind = CMD_HIGH_BYTE;
          cmd_o.last = (bl_dec == '0);
          if (bl_dec == '0) phase_d = PH_DONE;
        end
      end
      default: begin
        end_check = 1'b0;
        phase_d   = PH_DONE;
      end
    endcase

    // stream end before any outcome
    if (end_check && !reject && pos_next >= limit_i) reject = 1'b1;

    if (reject) begin
      phase_d     = PH_DONE;
      cmd_valid_o = 1'b1;
      cmd_o.kind  = CMD_REJECT;
      cmd_o.last  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HEADER;
      byte_pos_q    <= '0;
      bytes_left_q  <= '0;
      chunk_tag_q   <= '0;
      chunk_size_q  <= '0;
      format_ok_q   <= 1'b0;
      field_shift_q <= '0;
    end else if (in_fire_i) begin
      phase_q       <= phase_d;
      byte_pos_q    <= byte_pos_d;
      bytes_left_q  <= bytes_left_d;
      chunk_tag_q   <= chunk_tag_d;
      chunk_size_q  <= chunk_size_d;
      format_ok_q   <= format_ok_d;
      field_shift_q <= field_shift_d;
    end
  end

endmodule

// ----- src/wpp_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// wpp_cmd_queue
// short command queue between the parser and the sample stage
// ----------------------------------------------------------------------------
module wpp_cmd_queue
  import wpp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_cmd_i,
  output logic full_o,
  input  logic rd_en_i,
  output cmd_t rd_cmd_o,
  output logic empty_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_wr, do_rd;

  assign full_o   = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o  = (count_q == '0);
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && !empty_o;
  assign rd_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- src/wpp_back.sv -----
// ----------------------------------------------------------------------------
// wpp_back
// sample stage: pairs data bytes into q1.15 samples, holds the result register
// ----------------------------------------------------------------------------
module wpp_back
  import wpp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  cmd_t               q_cmd_i,
  output logic               q_rd_o,
  input  logic               pop_i,
  output logic               out_valid_o,
  output logic               status_o,
  output logic signed [15:0] sample_o,
  output logic               last_o
);

  logic               valid_q, valid_d;
  logic               status_q;
  logic signed [15:0] sample_q;
  logic               last_q;
  logic [7:0]         hold_q;
  logic               pop_fire;

  assign pop_fire = pop_i && valid_q;
  assign q_rd_o   = !q_empty_i && (!valid_q || pop_i);
  assign valid_d  = (valid_q && !pop_fire) || (q_rd_o && q_cmd_i.kind != CMD_LOW_BYTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      case (q_cmd_i.kind)
        CMD_LOW_BYTE: begin
          hold_q <= q_cmd_i.data;
        end
        CMD_HIGH_BYTE: begin
          status_q <= 1'b0;
          sample_q <= {q_cmd_i.data, hold_q};
          last_q   <= q_cmd_i.last;
        end
        default: begin
          status_q <= 1'b1;
          sample_q <= '0;
          last_q   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = valid_q;
  assign status_o    = status_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

endmodule

// ----- src/wav_pcm16_mono_stream_parser.sv -----
// ----------------------------------------------------------------------------
// wav_pcm16_mono_stream_parser
// byte-wide riff/wave parser emitting mono pcm16 samples as q1.15
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// input     in         push / full         data_byte_i, first_byte_i
// result    out        pop / empty         status_o, sample_o, last_o
// config    in         cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// one byte per cycle is taken whenever the command queue has room; the parser
// decides each byte in the cycle of its transfer
// a sample reaches the result ports through the command queue and the result register
// after its high byte transfer, when the result register is free
// full rises only when all queue entries wait on a stalled result register
// reset clears the parse to the header phase, rate to 48000, length to 0
// ----------------------------------------------------------------------------
module wav_pcm16_mono_stream_parser
  import wpp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               first_byte_i,
  // results
  output logic               empty,
  input  logic               pop,
  output logic               status_o,
  output logic signed [15:0] sample_o,
  output logic               last_o,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i
);

  logic [31:0] expected_rate_q;
  logic [31:0] stream_length_q;
  logic        in_fire;
  logic        cmd_valid;
  cmd_t        cmd, q_cmd;
  logic        q_empty, q_rd;
  logic        out_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_rate_q <= EXPECTED_RATE_RST;
      stream_length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXPECTED_RATE: expected_rate_q <= cfg_wdata_i;
        CFG_STREAM_LENGTH: stream_length_q <= cfg_wdata_i;
        default:           expected_rate_q <= expected_rate_q;
      endcase
    end
  end

  // a byte transfers whenever the queue can take its command
  assign in_fire = push && !full;

  wpp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .expected_rate_i(expected_rate_q),
    .limit_i        (stream_length_q[LENGTH_BITS-1:0]),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd)
  );

  // commands: low data byte, high data byte with last flag, rejection
  wpp_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (in_fire && cmd_valid),
    .wr_cmd_i(cmd),
    .full_o  (full),
    .rd_en_i (q_rd),
    .rd_cmd_o(q_cmd),
    .empty_o (q_empty)
  );

  wpp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_cmd_i    (q_cmd),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .out_valid_o(out_valid),
    .status_o   (status_o),
    .sample_o   (sample_o),
    .last_o     (last_o)
  );

  assign empty = !out_valid;

endmodule

// ----- src/wpp_checker.sv -----
// ----------------------------------------------------------------------------
// wpp_checker
// port-level checks of the stream parser, bound to the top level
// ----------------------------------------------------------------------------
module wpp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic               status_o,
  input logic signed [15:0] sample_o,
  input logic               last_o
);

  // a rejection carries a zero sample and ends the file
  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> (sample_o == 16'sd0 && last_o))
    else $error("rejection result with nonzero sample or without last");

  // a waiting result that is not taken stays unchanged
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(sample_o) && $stable(status_o) && $stable(last_o)))
    else $error("stalled result changed");

  // the queue only fills behind a waiting result
  a_full_means_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("full without a waiting result");

  // reset leaves no result and room for input
  a_reset_clear: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("result or full seen right after reset");

endmodule

bind wav_pcm16_mono_stream_parser wpp_checker u_wpp_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .status_o(status_o),
  .sample_o(sample_o),
  .last_o  (last_o)
);
